>>> rtl/core/ade_pkg.sv
package ade_pkg;

  // Default data widths
  localparam int SAMPLE_BITS_DEF    = 24;
  localparam int GAIN_FRAC_BITS_DEF = 16;

  // Configuration register widths
  localparam int TERMS_BITS     = 2;
  localparam int DIFF_GAIN_BITS = 18;
  localparam int ADV_GAIN_BITS  = 19;
  localparam int CFG_DATA_BITS  = ADV_GAIN_BITS;
  localparam int CFG_INDEX_BITS = 2;

  // Register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_TERMS     = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DIFF_GAIN = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ADV_GAIN  = 2'd2;

  localparam logic [TERMS_BITS-1:0] TERMS_RESET = 2'd3;
  localparam int TERM_DIFF_BIT = 0;
  localparam int TERM_ADV_BIT  = 1;

  // Result queue
  localparam int MAX_RESULTS  = 4;
  localparam int RES_CNT_BITS = $clog2(MAX_RESULTS + 1);
  localparam int QUEUE_DEPTH  = 8;

  // One write into the result queue: how many words and whether the row closes
  typedef struct packed {
    logic [RES_CNT_BITS-1:0] cnt;
    logic                    row_end;
  } ade_wr_t;

endpackage

>>> rtl/core/advection_diffusion_euler_step.sv
// Channel  | Handshake            | Payload
// ---------+----------------------+-----------------------------------
// in       | in_valid / in_ready  | in_sample, in_row_last
// out      | out_valid / out_ready| out_value, out_row_end, out_last
// cfg      | cfg_we (no wait)     | cfg_index, cfg_wdata
//
// One sample is taken per cycle while in_ready is high. The first word an item
// causes passes the window, multiply and round stages, then enters the queue.
// Results drain one word per cycle while out_ready is high from an eight-entry
// queue; in_ready drops when queued plus in-flight words leave no room for the
// words this sample releases. Reset (rst_n low, synchronous) empties the pipeline
// and queue, clears the window and row position, sets terms to both, gains to zero.
module advection_diffusion_euler_step
  import ade_pkg::*;
#(
  parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
  parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0]   cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [SAMPLE_BITS-1:0]     in_sample,
  input  logic                       in_row_last,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [SAMPLE_BITS-1:0]     out_value,
  output logic                       out_row_end,
  output logic                       out_last
);

  localparam int SB = SAMPLE_BITS;
  localparam int RW = $clog2(QUEUE_DEPTH + 1);

  // Row position, saturating at the steady code
  localparam logic [2:0] POS_HEAD   = 3'd0;
  localparam logic [2:0] POS_SECOND = 3'd1;
  localparam logic [2:0] POS_THIRD  = 3'd2;
  localparam logic [2:0] POS_FOURTH = 3'd3;
  localparam logic [2:0] POS_STEADY = 3'd4;

  typedef struct packed {
    logic [2:0]              pos;
    logic                    fin;
    logic [RES_CNT_BITS-1:0] cnt;
    logic [SB-1:0]           s;
    logic [SB-1:0]           w0;
    logic [SB-1:0]           w1;
    logic [SB-1:0]           first;
  } meta_t;

  // Configuration registers
  logic [TERMS_BITS-1:0]     terms_r;
  logic [DIFF_GAIN_BITS-1:0] diff_gain_r;
  logic [ADV_GAIN_BITS-1:0]  adv_gain_r;

  // Row state
  logic [2:0]    pos_r;
  logic [SB-1:0] w0_r, w1_r, first_r;
  logic signed [SB+1:0] rec0_r;

  // Pipeline
  logic                 acc;
  logic [RES_CNT_BITS-1:0] n_new;
  logic signed [SB+1:0] a1_nxt, a1_r;
  logic signed [SB:0]   a2_nxt, a2_r;
  meta_t                s1_nxt, s1_r, s2_r, s3_r;
  logic                 s1_v_r, s2_v_r, s3_v_r;
  logic signed [SB+1:0] d;

  // Word reservation
  logic [RW-1:0] rsv_r, rsv_nxt;
  logic          out_fire;

  // Result forming
  logic [SB+2:0] cand_sum [4];
  logic [SB-1:0] cand_sat [4];
  logic [MAX_RESULTS-1:0][SB-1:0] wr_value;
  ade_wr_t       wr;

  function automatic logic [SB-1:0] sat_sample(input logic [SB+2:0] x);
    logic [3:0] top;
    top = x[SB+2:SB-1];
    if ((&top) || !(|top)) begin
      return x[SB-1:0];
    end
    return {x[SB+2], {(SB-1){~x[SB+2]}}};
  endfunction

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      terms_r     <= TERMS_RESET;
      diff_gain_r <= '0;
      adv_gain_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TERMS:     terms_r     <= cfg_wdata[TERMS_BITS-1:0];
        REG_DIFF_GAIN: diff_gain_r <= cfg_wdata[DIFF_GAIN_BITS-1:0];
        REG_ADV_GAIN:  adv_gain_r  <= cfg_wdata[ADV_GAIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- accept ----------------
  // Take a word only while the queue can absorb the words it releases on top of
  // everything already promised to it.
  assign in_ready = (rsv_r + RW'(n_new)) <= RW'(QUEUE_DEPTH);
  assign acc      = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // Words released by this sample
  always_comb begin
    case (pos_r)
      POS_HEAD:   n_new = in_row_last ? RES_CNT_BITS'(1) : RES_CNT_BITS'(0);
      POS_SECOND: n_new = in_row_last ? RES_CNT_BITS'(2) : RES_CNT_BITS'(0);
      POS_THIRD:  n_new = in_row_last ? RES_CNT_BITS'(3) : RES_CNT_BITS'(0);
      POS_FOURTH: n_new = in_row_last ? RES_CNT_BITS'(4) : RES_CNT_BITS'(3);
      default:    n_new = in_row_last ? RES_CNT_BITS'(2) : RES_CNT_BITS'(1);
    endcase
  end

  // Stencil differences: second difference and backward difference
  assign a1_nxt = {{2{w1_r[SB-1]}}, w1_r} + {{2{in_sample[SB-1]}}, in_sample}
                - {w0_r[SB-1], w0_r, 1'b0};
  assign a2_nxt = {w0_r[SB-1], w0_r} - {w1_r[SB-1], w1_r};

  always_comb begin
    s1_nxt.pos   = pos_r;
    s1_nxt.fin   = in_row_last;
    s1_nxt.cnt   = n_new;
    s1_nxt.s     = in_sample;
    s1_nxt.w0    = w0_r;
    s1_nxt.w1    = w1_r;
    s1_nxt.first = first_r;
  end

  // Advance the window and row position on every accepted sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= POS_HEAD;
      w0_r    <= '0;
      w1_r    <= '0;
      first_r <= '0;
    end else if (acc) begin
      w1_r <= w0_r;
      w0_r <= in_sample;
      if (pos_r == POS_HEAD) begin
        first_r <= in_sample;
      end
      if (in_row_last) begin
        pos_r <= POS_HEAD;
      end else if (pos_r != POS_STEADY) begin
        pos_r <= pos_r + 3'd1;
      end
    end
  end

  // ---------------- pipeline ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= acc;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
    a1_r <= a1_nxt;
    a2_r <= a2_nxt;
    s2_r <= s1_r;
    s3_r <= s2_r;
  end

  // Multiply, round and clamp the increment; lands alongside stage 3
  ade_incr #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) u_incr (
    .clk        (clk),
    .terms_i    (terms_r),
    .diff_gain_i(diff_gain_r),
    .adv_gain_i (adv_gain_r),
    .a1_i       (a1_r),
    .a2_i       (a2_r),
    .d_o        (d)
  );

  // Hold the newest increment for the mirrored end and the delayed interior point
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec0_r <= '0;
    end else if (s3_v_r && (s3_r.pos inside {POS_THIRD, POS_FOURTH, POS_STEADY})) begin
      rec0_r <= d;
    end
  end

  // ---------------- result forming ----------------
  assign cand_sum[0] = {{3{s3_r.first[SB-1]}}, s3_r.first} - {d[SB+1], d};
  assign cand_sum[1] = {{3{s3_r.w0[SB-1]}}, s3_r.w0} + {d[SB+1], d};
  assign cand_sum[2] = {{3{s3_r.w1[SB-1]}}, s3_r.w1} + {rec0_r[SB+1], rec0_r};
  assign cand_sum[3] = {{3{s3_r.s[SB-1]}}, s3_r.s} - {rec0_r[SB+1], rec0_r};

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      cand_sat[k] = sat_sample(cand_sum[k]);
    end
  end

  // Short rows pass through; the fourth sample releases the row head
  always_comb begin
    wr_value = '0;
    case (s3_r.pos)
      POS_HEAD: begin
        wr_value[0] = s3_r.s;
      end
      POS_SECOND: begin
        wr_value[0] = s3_r.first;
        wr_value[1] = s3_r.s;
      end
      POS_THIRD: begin
        wr_value[0] = s3_r.first;
        wr_value[1] = s3_r.w0;
        wr_value[2] = s3_r.s;
      end
      POS_FOURTH: begin
        wr_value[0] = cand_sat[0];
        wr_value[1] = cand_sat[2];
        wr_value[2] = cand_sat[1];
        wr_value[3] = cand_sat[3];
      end
      default: begin
        wr_value[0] = cand_sat[1];
        wr_value[1] = cand_sat[3];
      end
    endcase
  end

  assign wr.cnt     = s3_v_r ? s3_r.cnt : '0;
  assign wr.row_end = s3_r.fin;

  ade_resq #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_resq (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_i       (wr),
    .wr_value_i (wr_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_value  (out_value),
    .out_row_end(out_row_end),
    .out_last   (out_last)
  );

  // Count words promised at accept and drop one per delivered word
  assign rsv_nxt = rsv_r + (acc ? RW'(n_new) : RW'(0)) - RW'(out_fire);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rsv_r <= '0;
    end else begin
      rsv_r <= rsv_nxt;
    end
  end

endmodule

>>> rtl/core/ade_incr.sv
module ade_incr
  import ade_pkg::*;
#(
  parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
  parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic [TERMS_BITS-1:0]             terms_i,
  input  logic [DIFF_GAIN_BITS-1:0]         diff_gain_i,
  input  logic [ADV_GAIN_BITS-1:0]          adv_gain_i,
  input  logic signed [SAMPLE_BITS+1:0]     a1_i,
  input  logic signed [SAMPLE_BITS:0]       a2_i,
  output logic signed [SAMPLE_BITS+1:0]     d_o
);

  localparam int G1W = DIFF_GAIN_BITS + 1;
  localparam int G2W = ADV_GAIN_BITS + 1;
  localparam int PW  = SAMPLE_BITS + 2 + G1W;
  localparam int SW  = PW + 2;
  localparam int DW  = SAMPLE_BITS + 2;
  localparam logic signed [SW-1:0] RND = {{(SW-1){1'b0}}, 1'b1} << (GAIN_FRAC_BITS - 1);

  logic signed [G1W-1:0] g1;
  logic signed [G2W-1:0] adv_ext;
  logic signed [G2W-1:0] g2;
  logic signed [PW-1:0]  p1_nxt, p2_nxt;
  logic signed [PW-1:0]  p1_r, p2_r;
  logic signed [SW-1:0]  sum_w;
  logic signed [SW-1:0]  sh;
  logic [SW-DW:0]        hi;
  logic                  ovf;
  logic signed [DW-1:0]  d_nxt;
  logic signed [DW-1:0]  d_r;

  // Gate each gain by its term enable; advection enters with a negative sign
  assign g1      = terms_i[TERM_DIFF_BIT] ? $signed({1'b0, diff_gain_i}) : '0;
  assign adv_ext = $signed({adv_gain_i[ADV_GAIN_BITS-1], adv_gain_i});
  assign g2      = terms_i[TERM_ADV_BIT] ? -adv_ext : '0;

  assign p1_nxt = PW'(a1_i) * PW'(g1);
  assign p2_nxt = PW'(a2_i) * PW'(g2);

  always_ff @(posedge clk) begin
    p1_r <= p1_nxt;
    p2_r <= p2_nxt;
  end

  // Round to nearest, ties up, then clamp to the increment width
  assign sum_w = SW'(p1_r) + SW'(p2_r) + RND;
  assign sh    = sum_w >>> GAIN_FRAC_BITS;
  assign hi    = sh[SW-1:DW-1];
  assign ovf   = !((&hi) || !(|hi));
  assign d_nxt = ovf ? $signed({sh[SW-1], {(DW-1){~sh[SW-1]}}}) : sh[DW-1:0];

  always_ff @(posedge clk) begin
    d_r <= d_nxt;
  end

  assign d_o = d_r;

endmodule

>>> rtl/core/ade_resq.sv
module ade_resq
  import ade_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  ade_wr_t                                  wr_i,
  input  logic [MAX_RESULTS-1:0][SAMPLE_BITS-1:0]  wr_value_i,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic [SAMPLE_BITS-1:0]                   out_value,
  output logic                                     out_row_end,
  output logic                                     out_last
);

  localparam int AW = $clog2(QUEUE_DEPTH);

  logic [SAMPLE_BITS-1:0] mem_value [QUEUE_DEPTH];
  logic                   mem_end   [QUEUE_DEPTH];
  logic                   mem_last  [QUEUE_DEPTH];

  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   fill_r;
  logic [AW-1:0] wp_nxt, rp_nxt;
  logic [AW:0]   fill_nxt;
  logic          pop;
  logic [AW-1:0] wr_idx  [MAX_RESULTS];
  logic          wr_en   [MAX_RESULTS];
  logic          wr_last [MAX_RESULTS];

  always_comb begin
    for (int k = 0; k < MAX_RESULTS; k++) begin
      wr_idx[k]  = wp_r + AW'(k);
      wr_en[k]   = RES_CNT_BITS'(k) < wr_i.cnt;
      wr_last[k] = RES_CNT_BITS'(k + 1) == wr_i.cnt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_RESULTS; k++) begin
      if (wr_en[k]) begin
        mem_value[wr_idx[k]] <= wr_value_i[k];
        mem_end[wr_idx[k]]   <= wr_last[k] && wr_i.row_end;
        mem_last[wr_idx[k]]  <= wr_last[k];
      end
    end
  end

  assign out_valid   = fill_r != '0;
  assign out_value   = mem_value[rp_r];
  assign out_row_end = mem_end[rp_r];
  assign out_last    = mem_last[rp_r];

  assign pop      = out_valid && out_ready;
  assign wp_nxt   = wp_r + AW'(wr_i.cnt);
  assign rp_nxt   = rp_r + AW'(pop);
  assign fill_nxt = fill_r + (AW+1)'(wr_i.cnt) - (AW+1)'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      rp_r   <= '0;
      fill_r <= '0;
    end else begin
      wp_r   <= wp_nxt;
      rp_r   <= rp_nxt;
      fill_r <= fill_nxt;
    end
  end

endmodule
